[sv/fqs_pkg.sv]
// shared constants, codes and types of the searchable vertex queue
package fqs_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int VERTEX_BITS = 16;
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] CMD_PUSH   = 2'd0;
    localparam logic [1:0] CMD_POP    = 2'd1;
    localparam logic [1:0] CMD_SEARCH = 2'd2;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef logic [VERTEX_BITS-1:0] vertex_t;
    typedef logic [COUNT_W-1:0]     count_t;

    typedef struct packed {
        logic    push;
        logic    pop;
        logic    search;
        vertex_t value;
    } fqs_ctl_t;

endpackage

[sv/fifo_queue_with_search.sv]
// top level of the vertex queue with membership search, built as a row of slots
//
// An item is taken at a rising edge with start high and busy low. busy is
// always low: the row of slots takes one item in every cycle.
// cmd selects push at tail, pop of the head, or search for vertex_value;
// the unused command code changes nothing and reports done.
// Slot 0 holds the head; a pop shifts every slot one place toward it, a push
// fills the first empty slot, a search compares all slots at once.
// Each item gives one result, with done high for exactly one cycle: status,
// found, head_vertex, head_valid and entry_count as they stand after the item.
// The result of an item is registered in stage 1 (state, head, count and
// per-slot hits) and then in the stage 2 result registers; throughput is one
// item per cycle, and the per-slot hit register feeds the hit reduction.
// The receiver cannot stall: a result is shown once and is gone next cycle.
// Reset empties the queue and clears done; slot contents are not cleared.
// A push into a full queue is dropped with status full, and a pop on an
// empty queue is refused with status empty; head_vertex reads zero when
// head_valid is low.
module fifo_queue_with_search
    import fqs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             cmd,
    input  logic [VERTEX_BITS-1:0] vertex_value,
    output logic                   done,
    output logic [1:0]             status,
    output logic                   found,
    output logic [VERTEX_BITS-1:0] head_vertex,
    output logic                   head_valid,
    output logic [COUNT_W-1:0]     entry_count
);

    fqs_ctl_t ctl;
    logic     accept;
    logic     full;
    logic     empty;
    logic     push_ok;
    logic     pop_ok;
    logic     [1:0] status_next;

    vertex_t                value_arr      [QUEUE_DEPTH];
    vertex_t                value_next_arr [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] valid_vec;
    logic [QUEUE_DEPTH-1:0] valid_next_vec;
    logic [QUEUE_DEPTH-1:0] hit_vec;

    count_t count_reg;
    count_t count_next;

    logic       s1_vld_reg;
    logic [1:0] s1_status_reg;
    vertex_t    s1_head_reg;
    logic       s1_head_valid_reg;
    count_t     s1_count_reg;

    logic       done_reg;
    logic [1:0] status_reg;
    logic       found_reg;
    vertex_t    head_reg;
    logic       head_valid_reg;
    count_t     entry_count_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = valid_vec[QUEUE_DEPTH-1];
    assign empty  = !valid_vec[0];

    always_comb
    begin
        push_ok     = 1'b0;
        pop_ok      = 1'b0;
        status_next = ST_DONE;
        count_next  = count_reg;
        unique case (cmd)
            CMD_PUSH:
            begin
                if (full)
                    status_next = ST_FULL;
                else
                begin
                    push_ok    = accept;
                    count_next = count_reg + count_t'(1);
                end
            end
            CMD_POP:
            begin
                if (empty)
                    status_next = ST_EMPTY;
                else
                begin
                    pop_ok     = accept;
                    count_next = count_reg - count_t'(1);
                end
            end
            default:
            begin
                status_next = ST_DONE;
            end
        endcase
        ctl.push   = push_ok;
        ctl.pop    = pop_ok;
        ctl.search = accept && (cmd == CMD_SEARCH);
        ctl.value  = vertex_value;
    end

    genvar i;
    generate
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin : g_slot
            logic    left_valid;
            vertex_t right_value;
            logic    right_valid;

            if (i == 0)
            begin : g_first
                assign left_valid = 1'b1;
            end
            else
            begin : g_inner
                assign left_valid = valid_vec[i-1];
            end

            if (i == QUEUE_DEPTH - 1)
            begin : g_last
                assign right_value = '0;
                assign right_valid = 1'b0;
            end
            else
            begin : g_body
                assign right_value = value_arr[i+1];
                assign right_valid = valid_vec[i+1];
            end

            fqs_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl),
                .left_valid  (left_valid),
                .right_value (right_value),
                .right_valid (right_valid),
                .value       (value_arr[i]),
                .valid       (valid_vec[i]),
                .value_next  (value_next_arr[i]),
                .valid_next  (valid_next_vec[i]),
                .hit         (hit_vec[i])
            );
        end
    endgenerate

    // stage 1: state update, head and count after the item, per-slot hits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= accept;
            if (accept)
                count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_status_reg     <= status_next;
        s1_head_valid_reg <= valid_next_vec[0];
        s1_head_reg       <= valid_next_vec[0] ? value_next_arr[0] : '0;
        s1_count_reg      <= accept ? count_next : count_reg;
    end

    // stage 2: hit reduction and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= s1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        status_reg      <= s1_status_reg;
        found_reg       <= |hit_vec;
        head_reg        <= s1_head_reg;
        head_valid_reg  <= s1_head_valid_reg;
        entry_count_reg <= s1_count_reg;
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign found       = found_reg;
    assign head_vertex = head_reg;
    assign head_valid  = head_valid_reg;
    assign entry_count = entry_count_reg;

    a_result_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 2))
        else $error("result without a matching item");

    a_head_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (head_valid == (entry_count != '0)))
        else $error("head valid disagrees with entry count");

    a_slots_match_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(count_reg))
        else $error("occupied slots disagree with entry count");

    a_hit_only_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        (done && found) |-> (status == ST_DONE))
        else $error("search hit reported with a refused status");

endmodule

[sv/fqs_cell.sv]
// one queue slot: holds a vertex, shifts toward the head on pop, compares on search
module fqs_cell
    import fqs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  fqs_ctl_t ctl,
    input  logic     left_valid,
    input  vertex_t  right_value,
    input  logic     right_valid,
    output vertex_t  value,
    output logic     valid,
    output vertex_t  value_next,
    output logic     valid_next,
    output logic     hit
);

    vertex_t value_reg;
    logic    valid_reg;
    logic    hit_reg;
    logic    hit_next;

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        priority if (ctl.pop)
        begin
            value_next = right_value;
            valid_next = right_valid;
        end
        else if (ctl.push && left_valid && !valid_reg)
        begin
            value_next = ctl.value;
            valid_next = 1'b1;
        end
        else
        begin
            value_next = value_reg;
            valid_next = valid_reg;
        end
        hit_next = ctl.search && valid_reg && (value_reg == ctl.value);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;
    assign hit   = hit_reg;

endmodule
